// File: hdl/detector_output_decode_assert.svh
// assertion macros for the detector output decode
`ifndef DETECTOR_OUTPUT_DECODE_ASSERT_SVH
`define DETECTOR_OUTPUT_DECODE_ASSERT_SVH

// condition that must hold at every edge out of reset
`define DOD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// consequence that must hold in the same cycle as the antecedent
`define DOD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hdl/dod_pkg.sv
package dod_pkg;

	localparam int VALUE_W     = 24;
	localparam int FRAC_BITS   = 12;
	localparam int PROD_W      = 2 * VALUE_W;
	localparam int MAX_CLASSES = 128;
	localparam int CLASS_IDX_W = $clog2(MAX_CLASSES);
	localparam int CLASS_W     = CLASS_IDX_W + 1;
	localparam int LEN_W       = 8;
	localparam int THR_W       = 13;
	localparam int CONF_W      = 13;
	localparam int SCALE_W     = 16;
	localparam int SCALE_FRAC  = 8;
	localparam int MASK_W      = 64;
	localparam int BOX_W       = 16;
	localparam int LEVEL_W     = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int DIFF_W      = VALUE_W + 2;
	localparam int NUM_W       = DIFF_W + SCALE_W;
	localparam int EDGE_SHIFT  = SCALE_FRAC + FRAC_BITS + 1;
	localparam int SIZE_SHIFT  = SCALE_FRAC + FRAC_BITS;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [CLASS_W-1:0] class_t;
	typedef logic signed [BOX_W-1:0]   box_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_LENGTH       = 3'd0,
		CFG_SCORE_THRESHOLD  = 3'd1,
		CFG_SCALE_X          = 3'd2,
		CFG_SCALE_Y          = 3'd3,
		CFG_HIGH_MASK_LOW    = 3'd4,
		CFG_HIGH_MASK_HIGH   = 3'd5,
		CFG_MEDIUM_MASK_LOW  = 3'd6,
		CFG_MEDIUM_MASK_HIGH = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		KIND_DETECTION = 1'b0,
		KIND_SUMMARY   = 1'b1
	} result_kind_t;

	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_LOW    = 2'd0,
		LEVEL_MEDIUM = 2'd1,
		LEVEL_HIGH   = 2'd2
	} danger_t;

	// positions inside a prediction row
	localparam logic [LEN_W-1:0] POS_CX    = 8'd0;
	localparam logic [LEN_W-1:0] POS_CY    = 8'd1;
	localparam logic [LEN_W-1:0] POS_W     = 8'd2;
	localparam logic [LEN_W-1:0] POS_H     = 8'd3;
	localparam logic [LEN_W-1:0] POS_OBJ   = 8'd4;
	localparam logic [LEN_W-1:0] ROW_MIN   = 8'd5;
	localparam logic [LEN_W-1:0] CLS_START = 8'd5;

	localparam value_t VALUE_ONE = value_t'(1 << FRAC_BITS);
	localparam value_t VALUE_MAX = value_t'((1 << (VALUE_W - 1)) - 1);
	localparam value_t VALUE_MIN = value_t'(-(1 << (VALUE_W - 1)));
	localparam class_t NO_CLASS  = class_t'(-1);
	localparam box_t   BOX_MAX   = box_t'((1 << (BOX_W - 1)) - 1);
	localparam box_t   BOX_MIN   = box_t'(-(1 << (BOX_W - 1)));
	localparam logic [CONF_W-1:0] CONF_MAX = CONF_W'(1 << FRAC_BITS);

	localparam logic [LEN_W-1:0]   ROW_LENGTH_RST = 8'd85;
	localparam logic [THR_W-1:0]   THRESHOLD_RST  = 13'd1024;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd256;
	localparam logic [MASK_W-1:0]  HIGH_LOW_RST   = 64'h0000_0800_0000_0000;
	localparam logic [MASK_W-1:0]  HIGH_HIGH_RST  = 64'h0;
	localparam logic [MASK_W-1:0]  MED_LOW_RST    = 64'h0;
	localparam logic [MASK_W-1:0]  MED_HIGH_RST   = 64'h0000_0000_0000_1000;

endpackage

// File: hdl/dod_if.sv
interface dod_element_if;
	logic              valid;
	logic              ready;
	dod_pkg::value_t   element_value;
	logic              frame_end;

	modport source (output valid, output element_value, output frame_end, input ready);
	modport sink   (input valid, input element_value, input frame_end, output ready);
endinterface

interface dod_result_if;
	logic                              valid;
	logic                              ready;
	logic                              result_kind;
	dod_pkg::class_t                   class_index;
	logic [dod_pkg::CONF_W-1:0]        confidence;
	dod_pkg::box_t                     box_left;
	dod_pkg::box_t                     box_top;
	dod_pkg::box_t                     box_width;
	dod_pkg::box_t                     box_height;
	logic [dod_pkg::LEVEL_W-1:0]       danger_level;
	logic                              last;

	modport source (
		output valid, output result_kind, output class_index, output confidence,
		output box_left, output box_top, output box_width, output box_height,
		output danger_level, output last, input ready
	);
	modport sink (
		input valid, input result_kind, input class_index, input confidence,
		input box_left, input box_top, input box_width, input box_height,
		input danger_level, input last, output ready
	);
endinterface

// File: hdl/detector_output_decode.sv
// Decodes a detector's prediction rows streamed one element per word in row-major
// order (cx, cy, w, h, objectness when the row has six or more elements, then one
// score per class), and emits a detection for each row whose best objectness times
// class score reaches the threshold, plus a frame summary word on frame end. One
// element word is taken every cycle unless the result side stalls; the five-stage
// pipeline has an input register, score product, best-class update, box products
// and result register. Only an element that closes a row with a detection and also
// ends the frame yields two result words, which holds the input back until the
// detection word is taken. Configuration writes are meant for when no word is in flight.
`include "detector_output_decode_assert.svh"

module detector_output_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	dod_element_if.sink                       elements,
	dod_result_if.source                      results,
	input  logic                              cfg_we,
	input  logic [dod_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dod_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration
	logic [dod_pkg::LEN_W-1:0]   row_length_q;
	logic [dod_pkg::THR_W-1:0]   score_threshold_q;
	logic [dod_pkg::SCALE_W-1:0] scale_x_q;
	logic [dod_pkg::SCALE_W-1:0] scale_y_q;
	logic [dod_pkg::MASK_W-1:0]  high_mask_low_q;
	logic [dod_pkg::MASK_W-1:0]  high_mask_high_q;
	logic [dod_pkg::MASK_W-1:0]  medium_mask_low_q;
	logic [dod_pkg::MASK_W-1:0]  medium_mask_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q       <= dod_pkg::ROW_LENGTH_RST;
			score_threshold_q  <= dod_pkg::THRESHOLD_RST;
			scale_x_q          <= dod_pkg::SCALE_RST;
			scale_y_q          <= dod_pkg::SCALE_RST;
			high_mask_low_q    <= dod_pkg::HIGH_LOW_RST;
			high_mask_high_q   <= dod_pkg::HIGH_HIGH_RST;
			medium_mask_low_q  <= dod_pkg::MED_LOW_RST;
			medium_mask_high_q <= dod_pkg::MED_HIGH_RST;
		end else if (cfg_we) begin
			case (dod_pkg::cfg_reg_t'(cfg_index))
				dod_pkg::CFG_ROW_LENGTH:       row_length_q <= cfg_data[dod_pkg::LEN_W-1:0];
				dod_pkg::CFG_SCORE_THRESHOLD:  score_threshold_q <= cfg_data[dod_pkg::THR_W-1:0];
				dod_pkg::CFG_SCALE_X:          scale_x_q <= cfg_data[dod_pkg::SCALE_W-1:0];
				dod_pkg::CFG_SCALE_Y:          scale_y_q <= cfg_data[dod_pkg::SCALE_W-1:0];
				dod_pkg::CFG_HIGH_MASK_LOW:    high_mask_low_q <= cfg_data;
				dod_pkg::CFG_HIGH_MASK_HIGH:   high_mask_high_q <= cfg_data;
				dod_pkg::CFG_MEDIUM_MASK_LOW:  medium_mask_low_q <= cfg_data;
				dod_pkg::CFG_MEDIUM_MASK_HIGH: medium_mask_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	logic det_pend_q, sum_pend_q;
	logic pair_free, out_hs;

	assign out_hs    = results.valid && results.ready;
	assign pair_free = !(det_pend_q || sum_pend_q) || (out_hs && !(det_pend_q && sum_pend_q));
	assign adv4      = !v_s4 || pair_free;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign elements.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= elements.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: input word and row position
	dod_pkg::value_t value_s1;
	logic            fend_s1;

	always_ff @(posedge clk) begin
		if (adv1 && elements.valid) begin
			value_s1 <= elements.element_value;
			fend_s1  <= elements.frame_end;
		end
	end

	logic [dod_pkg::LEN_W-1:0] pos_q;
	dod_pkg::value_t           center_x_q, center_y_q, box_w_raw_q, box_h_raw_q;
	dod_pkg::value_t           objectness_q;

	logic [dod_pkg::LEN_W-1:0] len_eff;
	logic                      has_obj;
	logic [dod_pkg::LEN_W:0]   pos_next;
	logic                      row_end_s1;
	logic                      obj_elem;
	logic                      class_elem;
	logic [dod_pkg::LEN_W-1:0] class_pos;
	logic                      class_ok_s1;
	dod_pkg::value_t           obj_factor;
	logic signed [dod_pkg::PROD_W-1:0] prod_c;
	logic                      fire1;

	assign len_eff     = (row_length_q < dod_pkg::ROW_MIN) ? dod_pkg::ROW_MIN : row_length_q;
	assign has_obj     = len_eff > dod_pkg::ROW_MIN;
	assign pos_next    = {1'b0, pos_q} + 1'b1;
	assign row_end_s1  = pos_next >= {1'b0, len_eff};
	assign obj_elem    = has_obj && (pos_q == dod_pkg::POS_OBJ);
	assign class_elem  = (pos_q >= dod_pkg::POS_OBJ) && !obj_elem;
	assign class_pos   = pos_q - (has_obj ? dod_pkg::CLS_START : dod_pkg::POS_OBJ);
	assign class_ok_s1 = class_elem
		&& ({1'b0, class_pos} < (dod_pkg::LEN_W + 1)'(dod_pkg::MAX_CLASSES));
	assign obj_factor  = has_obj ? objectness_q : dod_pkg::VALUE_ONE;
	assign prod_c      = obj_factor * value_s1;
	assign fire1       = v_s1 && adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			center_x_q   <= '0;
			center_y_q   <= '0;
			box_w_raw_q  <= '0;
			box_h_raw_q  <= '0;
			objectness_q <= '0;
		end else if (fire1) begin
			pos_q <= (row_end_s1 || fend_s1) ? '0 : pos_next[dod_pkg::LEN_W-1:0];
			if (pos_q == dod_pkg::POS_CX) center_x_q <= value_s1;
			if (pos_q == dod_pkg::POS_CY) center_y_q <= value_s1;
			if (pos_q == dod_pkg::POS_W)  box_w_raw_q <= value_s1;
			if (pos_q == dod_pkg::POS_H)  box_h_raw_q <= value_s1;
			if (obj_elem)                 objectness_q <= value_s1;
		end
	end

	// stage 2: scaled score and best class
	logic signed [dod_pkg::PROD_W-1:0] prod_s2;
	logic                              class_ok_s2;
	logic [dod_pkg::CLASS_IDX_W-1:0]   class_idx_s2;
	logic                              row_end_s2, fend_s2;
	dod_pkg::value_t                   cx_s2, cy_s2, w_s2, h_s2;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			prod_s2      <= prod_c;
			class_ok_s2  <= class_ok_s1;
			class_idx_s2 <= class_pos[dod_pkg::CLASS_IDX_W-1:0];
			row_end_s2   <= row_end_s1;
			fend_s2      <= fend_s1;
			cx_s2        <= center_x_q;
			cy_s2        <= center_y_q;
			w_s2         <= box_w_raw_q;
			h_s2         <= box_h_raw_q;
		end
	end

	dod_pkg::value_t                   best_score_q;
	dod_pkg::class_t                   best_class_q;
	logic signed [dod_pkg::PROD_W-1:0] prod_bias, prod_div;
	dod_pkg::value_t                   score_c;
	logic                              better;
	dod_pkg::value_t                   best_score_fin;
	dod_pkg::class_t                   best_class_fin;
	logic signed [dod_pkg::DIFF_W-1:0] dx_c, dy_c;
	logic                              fire2;

	// truncate toward zero: bias negatives before the arithmetic shift
	assign prod_bias = prod_s2 + $signed({{(dod_pkg::PROD_W - dod_pkg::FRAC_BITS){1'b0}},
		{dod_pkg::FRAC_BITS{prod_s2[dod_pkg::PROD_W-1]}}});
	assign prod_div  = prod_bias >>> dod_pkg::FRAC_BITS;

	always_comb begin
		if (prod_div > dod_pkg::PROD_W'(dod_pkg::VALUE_MAX)) begin
			score_c = dod_pkg::VALUE_MAX;
		end else if (prod_div < dod_pkg::PROD_W'(dod_pkg::VALUE_MIN)) begin
			score_c = dod_pkg::VALUE_MIN;
		end else begin
			score_c = prod_div[dod_pkg::VALUE_W-1:0];
		end
	end

	assign better         = class_ok_s2 && (score_c > best_score_q);
	assign best_score_fin = better ? score_c : best_score_q;
	assign best_class_fin = better ? dod_pkg::class_t'({1'b0, class_idx_s2}) : best_class_q;
	assign dx_c  = (dod_pkg::DIFF_W'(cx_s2) <<< 1) - dod_pkg::DIFF_W'(w_s2);
	assign dy_c  = (dod_pkg::DIFF_W'(cy_s2) <<< 1) - dod_pkg::DIFF_W'(h_s2);
	assign fire2 = v_s2 && adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= dod_pkg::NO_CLASS;
		end else if (fire2) begin
			if (row_end_s2 || fend_s2) begin
				best_score_q <= '0;
				best_class_q <= dod_pkg::NO_CLASS;
			end else begin
				best_score_q <= best_score_fin;
				best_class_q <= best_class_fin;
			end
		end
	end

	// stage 3: threshold, danger level and box products
	dod_pkg::value_t                   score_s3;
	dod_pkg::class_t                   class_s3;
	logic                              row_end_s3, fend_s3;
	logic signed [dod_pkg::DIFF_W-1:0] dx_s3, dy_s3;
	dod_pkg::value_t                   w_s3, h_s3;

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			score_s3   <= best_score_fin;
			class_s3   <= best_class_fin;
			row_end_s3 <= row_end_s2;
			fend_s3    <= fend_s2;
			dx_s3      <= dx_c;
			dy_s3      <= dy_c;
			w_s3       <= w_s2;
			h_s3       <= h_s2;
		end
	end

	logic                                frame_saw_high_q, frame_saw_medium_q;
	logic [2*dod_pkg::MASK_W-1:0]        high_all, medium_all;
	logic [dod_pkg::CLASS_IDX_W-1:0]     cls_sel;
	logic                                cls_valid;
	logic [dod_pkg::LEVEL_W-1:0]         level_c, frame_level_c;
	logic                                det_hit;
	logic [dod_pkg::CONF_W-1:0]          conf_c;
	logic signed [dod_pkg::NUM_W-1:0]    num_l_c, num_t_c, num_w_c, num_h_c;
	logic                                fire3;

	assign high_all   = {high_mask_high_q, high_mask_low_q};
	assign medium_all = {medium_mask_high_q, medium_mask_low_q};
	assign cls_sel    = class_s3[dod_pkg::CLASS_IDX_W-1:0];
	assign cls_valid  = !class_s3[dod_pkg::CLASS_W-1];
	assign det_hit    = row_end_s3 && (score_s3 >= $signed({1'b0, score_threshold_q}));
	assign fire3      = v_s3 && adv4;

	always_comb begin
		if (cls_valid && high_all[cls_sel]) begin
			level_c = dod_pkg::LEVEL_HIGH;
		end else if (cls_valid && medium_all[cls_sel]) begin
			level_c = dod_pkg::LEVEL_MEDIUM;
		end else begin
			level_c = dod_pkg::LEVEL_LOW;
		end
	end

	always_comb begin
		if (frame_saw_high_q || (det_hit && level_c == dod_pkg::LEVEL_HIGH)) begin
			frame_level_c = dod_pkg::LEVEL_HIGH;
		end else if (frame_saw_medium_q || (det_hit && level_c == dod_pkg::LEVEL_MEDIUM)) begin
			frame_level_c = dod_pkg::LEVEL_MEDIUM;
		end else begin
			frame_level_c = dod_pkg::LEVEL_LOW;
		end
	end

	always_comb begin
		if (score_s3[dod_pkg::VALUE_W-1]) begin
			conf_c = '0;
		end else if (score_s3 > $signed({1'b0, dod_pkg::CONF_MAX})) begin
			conf_c = dod_pkg::CONF_MAX;
		end else begin
			conf_c = score_s3[dod_pkg::CONF_W-1:0];
		end
	end

	assign num_l_c = dx_s3 * $signed({1'b0, scale_x_q});
	assign num_t_c = dy_s3 * $signed({1'b0, scale_y_q});
	assign num_w_c = w_s3 * $signed({1'b0, scale_x_q});
	assign num_h_c = h_s3 * $signed({1'b0, scale_y_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_saw_high_q   <= 1'b0;
			frame_saw_medium_q <= 1'b0;
		end else if (fire3) begin
			if (fend_s3) begin
				frame_saw_high_q   <= 1'b0;
				frame_saw_medium_q <= 1'b0;
			end else if (det_hit) begin
				if (level_c == dod_pkg::LEVEL_HIGH)   frame_saw_high_q <= 1'b1;
				if (level_c == dod_pkg::LEVEL_MEDIUM) frame_saw_medium_q <= 1'b1;
			end
		end
	end

	// stage 4: divide and saturate the box
	logic                               det_s4, sum_s4, det_last_s4;
	dod_pkg::class_t                    class_s4;
	logic [dod_pkg::CONF_W-1:0]         conf_s4;
	logic [dod_pkg::LEVEL_W-1:0]        level_s4, frame_level_s4;
	logic signed [dod_pkg::NUM_W-1:0]   num_l_s4, num_t_s4, num_w_s4, num_h_s4;

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			det_s4         <= det_hit;
			sum_s4         <= fend_s3;
			det_last_s4    <= !fend_s3;
			class_s4       <= class_s3;
			conf_s4        <= conf_c;
			level_s4       <= level_c;
			frame_level_s4 <= frame_level_c;
			num_l_s4       <= num_l_c;
			num_t_s4       <= num_t_c;
			num_w_s4       <= num_w_c;
			num_h_s4       <= num_h_c;
		end
	end

	function automatic dod_pkg::box_t box_scale(input logic signed [dod_pkg::NUM_W-1:0] n,
		input logic is_edge);
		logic signed [dod_pkg::NUM_W-1:0] b_edge;
		logic signed [dod_pkg::NUM_W-1:0] b_size;
		logic signed [dod_pkg::NUM_W-1:0] q;
		b_edge = n + $signed({{(dod_pkg::NUM_W - dod_pkg::EDGE_SHIFT){1'b0}},
			{dod_pkg::EDGE_SHIFT{n[dod_pkg::NUM_W-1]}}});
		b_size = n + $signed({{(dod_pkg::NUM_W - dod_pkg::SIZE_SHIFT){1'b0}},
			{dod_pkg::SIZE_SHIFT{n[dod_pkg::NUM_W-1]}}});
		q = is_edge ? (b_edge >>> dod_pkg::EDGE_SHIFT) : (b_size >>> dod_pkg::SIZE_SHIFT);
		if (q > dod_pkg::NUM_W'(dod_pkg::BOX_MAX)) begin
			box_scale = dod_pkg::BOX_MAX;
		end else if (q < dod_pkg::NUM_W'(dod_pkg::BOX_MIN)) begin
			box_scale = dod_pkg::BOX_MIN;
		end else begin
			box_scale = q[dod_pkg::BOX_W-1:0];
		end
	endfunction

	// result register: a detection word, then a summary word if both are due
	dod_pkg::class_t             class_q;
	logic [dod_pkg::CONF_W-1:0]  conf_q;
	dod_pkg::box_t               left_q, top_q, width_q, height_q;
	logic [dod_pkg::LEVEL_W-1:0] level_q, frame_level_q;
	logic                        det_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_pend_q <= 1'b0;
			sum_pend_q <= 1'b0;
		end else if (pair_free) begin
			det_pend_q <= v_s4 && det_s4;
			sum_pend_q <= v_s4 && sum_s4;
		end else if (out_hs) begin
			if (det_pend_q) det_pend_q <= 1'b0;
			else            sum_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_free && v_s4) begin
			class_q       <= class_s4;
			conf_q        <= conf_s4;
			left_q        <= box_scale(num_l_s4, 1'b1);
			top_q         <= box_scale(num_t_s4, 1'b1);
			width_q       <= box_scale(num_w_s4, 1'b0);
			height_q      <= box_scale(num_h_s4, 1'b0);
			level_q       <= level_s4;
			frame_level_q <= frame_level_s4;
			det_last_q    <= det_last_s4;
		end
	end

	assign results.valid        = det_pend_q || sum_pend_q;
	assign results.result_kind  = det_pend_q ? dod_pkg::KIND_DETECTION : dod_pkg::KIND_SUMMARY;
	assign results.class_index  = det_pend_q ? class_q : '0;
	assign results.confidence   = det_pend_q ? conf_q : '0;
	assign results.box_left     = det_pend_q ? left_q : '0;
	assign results.box_top      = det_pend_q ? top_q : '0;
	assign results.box_width    = det_pend_q ? width_q : '0;
	assign results.box_height   = det_pend_q ? height_q : '0;
	assign results.danger_level = det_pend_q ? level_q : frame_level_q;
	assign results.last         = det_pend_q ? det_last_q : 1'b1;

	`DOD_ASSERT_ALWAYS(a_best_pair, (best_class_q == dod_pkg::NO_CLASS) == (best_score_q == '0), "best class and best score disagree")
	`DOD_ASSERT_IMPLIES(a_pair_last, det_pend_q && sum_pend_q, !det_last_q, "detection ahead of a summary marked last")
	`DOD_ASSERT_IMPLIES(a_conf_range, results.valid, results.confidence <= dod_pkg::CONF_MAX, "confidence above one")

endmodule
